// ===== rtl/core/rstt_pkg.sv =====
// ----------------------------------------------------------------------------
// rstt_pkg
// Shared types and codes of the retransmission tracker.
// ----------------------------------------------------------------------------
package rstt_pkg;

   localparam int SEQ_W    = 32;
   localparam int STAMP_W  = 32;
   localparam int HANDLE_W = 8;
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 4;
   localparam int TMO_W    = 16;
   localparam int CSR_IDX_W = 1;

   localparam int DEF_TABLE_DEPTH = 16;
   localparam int DEF_MAX_RESENDS = 8;

   localparam logic [CMD_W-1:0] CMD_SEND  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_QUEUE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ACK   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_TICK  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

   localparam logic [STATUS_W-1:0] ST_SENT_NEW  = 4'd0;
   localparam logic [STATUS_W-1:0] ST_QUEUED    = 4'd1;
   localparam logic [STATUS_W-1:0] ST_SENT_UNRE = 4'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 4'd3;
   localparam logic [STATUS_W-1:0] ST_RESEND    = 4'd4;
   localparam logic [STATUS_W-1:0] ST_ACK_HIT   = 4'd5;
   localparam logic [STATUS_W-1:0] ST_ACK_MISS  = 4'd6;
   localparam logic [STATUS_W-1:0] ST_TICK_DONE = 4'd7;
   localparam logic [STATUS_W-1:0] ST_CLEARED   = 4'd8;

   localparam logic [CSR_IDX_W-1:0] REG_RELIABLE_ENABLE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RESEND_TIMEOUT  = 1'd1;

   typedef struct packed {
      logic [SEQ_W-1:0]    seq;
      logic [STAMP_W-1:0]  stamp;
      logic [STAMP_W-1:0]  first;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

endpackage

// ===== rtl/core/rstt_cell.sv =====
// ----------------------------------------------------------------------------
// rstt_cell
// One table entry; loads a new item, takes its upper neighbour or restamps.
// ----------------------------------------------------------------------------
module rstt_cell (
   input  logic                             clock,
   input  logic                             load_en,
   input  logic                             shift_en,
   input  logic                             restamp_en,
   input  rstt_pkg::entry_type              load_data,
   input  rstt_pkg::entry_type              next_data,
   input  logic [rstt_pkg::STAMP_W-1:0]     now_ms,
   output rstt_pkg::entry_type              entry_q
);
   import rstt_pkg::*;

   entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (load_en) begin
         entry_in = load_data;
      end else if (shift_en) begin
         entry_in = next_data;
      end else if (restamp_en) begin
         entry_in.stamp = now_ms;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_q = entry_ff;

endmodule

// ===== rtl/core/reliable_send_retransmit_tracker.sv =====
// ----------------------------------------------------------------------------
// reliable_send_retransmit_tracker
// Sender-side retransmission table built as a row of entry cells.
// ----------------------------------------------------------------------------
// Commands enter on req_* when start is high and busy is low. Results leave on
// rsp_* for one cycle each, marked by rsp_valid; rsp_last flags the final one.
// Entries sit in cells 0..count-1 in insertion order, oldest in cell 0.
// Send, queue and clear put their result out in the cycle after acceptance and
// never raise busy, so they can follow one per cycle.
// An ack scans one cell per cycle from the oldest and answers on a hit or after
// the newest cell, or with no scan when the table is empty; on a hit the cells
// at and above the hole take their upper neighbour in the same cycle, closing
// the gap.
// A tick visits one cell per cycle from the oldest, giving at most one resend per
// cycle, each registered from the cell it visits, then tick done after the newest
// cell, or with no scan when the table is empty; busy clears with tick done.
// Acks and ticks read the table through a single cell port at the scan pointer.
// Commands 5 to 7 are dropped without a result.
// Reset empties the table, zeroes the sequence counter, sets reliable mode
// and a 200 ms timeout. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module reliable_send_retransmit_tracker #(
   parameter int TABLE_DEPTH = rstt_pkg::DEF_TABLE_DEPTH,
   parameter int MAX_RESENDS = rstt_pkg::DEF_MAX_RESENDS,
   parameter int CNT_W       = $clog2(TABLE_DEPTH) + 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [rstt_pkg::CMD_W-1:0]        req_command,
   input  logic [rstt_pkg::HANDLE_W-1:0]     req_payload_handle,
   input  logic [rstt_pkg::SEQ_W-1:0]        req_ack_seq,
   input  logic [rstt_pkg::STAMP_W-1:0]      req_now_ms,
   output logic                              rsp_valid,
   output logic [rstt_pkg::STATUS_W-1:0]     rsp_status,
   output logic [rstt_pkg::SEQ_W-1:0]        rsp_seq_out,
   output logic [rstt_pkg::HANDLE_W-1:0]     rsp_handle_out,
   output logic [rstt_pkg::STAMP_W-1:0]      rsp_oldest_age,
   output logic [CNT_W-1:0]                  rsp_pending_count,
   output logic                              rsp_last,
   input  logic                              csr_write_enable,
   input  logic [rstt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rstt_pkg::TMO_W-1:0]        csr_write_data
);
   import rstt_pkg::*;

   localparam int PTR_W = $clog2(TABLE_DEPTH);
   localparam int RES_W = $clog2(MAX_RESENDS + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);
   localparam logic [RES_W-1:0] MAX_RES  = RES_W'(MAX_RESENDS);

   typedef enum logic [1:0] {IDLE, ACK_SCAN, TICK_SCAN, TICK_DONE} state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [PTR_W-1:0]        ptr_ff, ptr_in;
   logic [SEQ_W-1:0]        last_seq_ff, last_seq_in;
   logic [SEQ_W-1:0]        ack_ff, ack_in;
   logic [STAMP_W-1:0]      now_ff, now_in;
   logic [STAMP_W-1:0]      oldest_ff, oldest_in;
   logic [RES_W-1:0]        resends_ff, resends_in;
   logic                    rel_ff, rel_in;
   logic [TMO_W-1:0]        tmo_ff, tmo_in;
   logic                    valid_ff, valid_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic [SEQ_W-1:0]        seq_ff, seq_in;
   logic [HANDLE_W-1:0]     handle_ff, handle_in;
   logic [STAMP_W-1:0]      age_ff, age_in;
   logic [CNT_W-1:0]        pend_ff, pend_in;
   logic                    last_ff, last_in;

   entry_type               cell_q [TABLE_DEPTH];
   entry_type               new_entry;
   entry_type               cur;
   logic [TABLE_DEPTH-1:0]  load_en, shift_en, restamp_en;
   logic                    accept, send_ok, ack_hit, do_resend, at_end;
   logic [STAMP_W-1:0]      cur_age, cur_first_age;

   assign accept = start && (state_ff == IDLE);
   assign busy   = (state_ff != IDLE);
   assign cur    = cell_q[ptr_ff];
   assign at_end = ({1'b0, ptr_ff} + CNT_W'(1)) == count_ff;
   assign cur_age       = now_ff - cur.stamp;
   assign cur_first_age = now_ff - cur.first;

   assign send_ok = accept && rel_ff && (count_ff != FULL_CNT)
                    && (req_command == CMD_SEND || req_command == CMD_QUEUE);
   assign ack_hit = (state_ff == ACK_SCAN) && (cur.seq == ack_ff);
   assign do_resend = (state_ff == TICK_SCAN) && (resends_ff != MAX_RES)
                      && (cur_age > {{(STAMP_W-TMO_W){1'b0}}, tmo_ff});

   always_comb begin
      new_entry.seq    = last_seq_ff + SEQ_W'(1);
      new_entry.stamp  = req_now_ms;
      new_entry.first  = req_now_ms;
      new_entry.handle = req_payload_handle;
   end

   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         load_en[i]    = send_ok && (count_ff[PTR_W-1:0] == PTR_W'(i));
         // cells at and above the hole take their upper neighbour
         shift_en[i]   = ack_hit && (PTR_W'(i) >= ptr_ff);
         restamp_en[i] = do_resend && (ptr_ff == PTR_W'(i));
      end
   end

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      entry_type nb;
      if (g == TABLE_DEPTH - 1) begin : g_top
         assign nb = cell_q[g];
      end else begin : g_mid
         assign nb = cell_q[g+1];
      end
      rstt_cell u_cell (
         .clock      (clock),
         .load_en    (load_en[g]),
         .shift_en   (shift_en[g]),
         .restamp_en (restamp_en[g]),
         .load_data  (new_entry),
         .next_data  (nb),
         .now_ms     (now_ff),
         .entry_q    (cell_q[g])
      );
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      last_seq_in = last_seq_ff;
      ack_in      = ack_ff;
      now_in      = now_ff;
      oldest_in   = oldest_ff;
      resends_in  = resends_ff;
      rel_in      = rel_ff;
      tmo_in      = tmo_ff;
      valid_in    = 1'b0;
      status_in   = status_ff;
      seq_in      = seq_ff;
      handle_in   = handle_ff;
      age_in      = '0;
      pend_in     = pend_ff;
      last_in     = 1'b1;

      if (csr_write_enable) begin
         case (csr_index)
            REG_RELIABLE_ENABLE: rel_in = csr_write_data[0];
            REG_RESEND_TIMEOUT:  tmo_in = csr_write_data;
            default: ;
         endcase
      end

      case (state_ff)
         IDLE: begin
            if (accept) begin
               case (req_command)
                  CMD_SEND, CMD_QUEUE: begin
                     valid_in  = 1'b1;
                     handle_in = req_payload_handle;
                     seq_in    = '0;
                     pend_in   = count_ff;
                     if (!rel_ff) begin
                        status_in = ST_SENT_UNRE;
                     end else if (count_ff == FULL_CNT) begin
                        status_in = ST_FULL;
                     end else begin
                        status_in   = (req_command == CMD_SEND) ? ST_SENT_NEW : ST_QUEUED;
                        seq_in      = new_entry.seq;
                        last_seq_in = new_entry.seq;
                        count_in    = count_ff + CNT_W'(1);
                        pend_in     = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_ACK: begin
                     ack_in = req_ack_seq;
                     ptr_in = '0;
                     if (count_ff == '0) begin
                        valid_in  = 1'b1;
                        status_in = ST_ACK_MISS;
                        seq_in    = req_ack_seq;
                        handle_in = '0;
                        pend_in   = '0;
                     end else begin
                        state_in = ACK_SCAN;
                     end
                  end
                  CMD_TICK: begin
                     now_in     = req_now_ms;
                     ptr_in     = '0;
                     oldest_in  = '0;
                     resends_in = '0;
                     if (count_ff == '0) begin
                        valid_in  = 1'b1;
                        status_in = ST_TICK_DONE;
                        seq_in    = '0;
                        handle_in = '0;
                        pend_in   = '0;
                     end else begin
                        state_in = TICK_SCAN;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in  = '0;
                     valid_in  = 1'b1;
                     status_in = ST_CLEARED;
                     seq_in    = '0;
                     handle_in = '0;
                     pend_in   = '0;
                  end
                  default: ;
               endcase
            end
         end
         ACK_SCAN: begin
            if (ack_hit) begin
               valid_in  = 1'b1;
               status_in = ST_ACK_HIT;
               seq_in    = ack_ff;
               handle_in = cur.handle;
               count_in  = count_ff - CNT_W'(1);
               pend_in   = count_ff - CNT_W'(1);
               state_in  = IDLE;
            end else if (at_end) begin
               valid_in  = 1'b1;
               status_in = ST_ACK_MISS;
               seq_in    = ack_ff;
               handle_in = '0;
               pend_in   = count_ff;
               state_in  = IDLE;
            end else begin
               ptr_in = ptr_ff + PTR_W'(1);
            end
         end
         TICK_SCAN: begin
            if (cur_first_age > oldest_ff) begin
               oldest_in = cur_first_age;
            end
            if (do_resend) begin
               valid_in   = 1'b1;
               last_in    = 1'b0;
               status_in  = ST_RESEND;
               seq_in     = cur.seq;
               handle_in  = cur.handle;
               pend_in    = count_ff;
               resends_in = resends_ff + RES_W'(1);
            end
            if (at_end) begin
               state_in = TICK_DONE;
            end else begin
               ptr_in = ptr_ff + PTR_W'(1);
            end
         end
         TICK_DONE: begin
            valid_in  = 1'b1;
            status_in = ST_TICK_DONE;
            seq_in    = '0;
            handle_in = '0;
            age_in    = oldest_ff;
            pend_in   = count_ff;
            state_in  = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= IDLE;
         count_ff    <= '0;
         last_seq_ff <= '0;
         rel_ff      <= 1'b1;
         tmo_ff      <= TMO_W'(200);
         valid_ff    <= 1'b0;
         resends_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         last_seq_ff <= last_seq_in;
         rel_ff      <= rel_in;
         tmo_ff      <= tmo_in;
         valid_ff    <= valid_in;
         resends_ff  <= resends_in;
      end
      ptr_ff     <= ptr_in;
      ack_ff     <= ack_in;
      now_ff     <= now_in;
      oldest_ff  <= oldest_in;
      status_ff  <= status_in;
      seq_ff     <= seq_in;
      handle_ff  <= handle_in;
      age_ff     <= age_in;
      pend_ff    <= pend_in;
      last_ff    <= last_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_seq_out       = seq_ff;
   assign rsp_handle_out    = handle_ff;
   assign rsp_oldest_age    = age_ff;
   assign rsp_pending_count = pend_ff;
   assign rsp_last          = last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT) else $error("entry count beyond table depth");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      valid_ff && last_ff |-> !busy) else $error("busy after final result");

   a_resend_not_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && status_ff == ST_RESEND |-> !last_ff)
      else $error("resend marked final");

   a_resend_limit: assert property (@(posedge clock) disable iff (reset)
      resends_ff <= MAX_RES) else $error("resend limit exceeded");

   a_hit_shrinks: assert property (@(posedge clock) disable iff (reset)
      ack_hit |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("ack hit did not free an entry");

endmodule

// ===== test/reliable_send_retransmit_tracker_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reliable_send_retransmit_tracker_checker
// Watches the command and result channels of the retransmission tracker. It
// keeps its own copy of the table, works out the results that each accepted
// command should give, and compares every result field by field.
// ----------------------------------------------------------------------------
module reliable_send_retransmit_tracker_checker #(
   parameter int DEPTH   = rstt_pkg::DEF_TABLE_DEPTH,
   parameter int RESENDS = rstt_pkg::DEF_MAX_RESENDS,
   parameter int CNT_W   = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic [rstt_pkg::CMD_W-1:0]        req_command,
   input  logic [rstt_pkg::HANDLE_W-1:0]     req_payload_handle,
   input  logic [rstt_pkg::SEQ_W-1:0]        req_ack_seq,
   input  logic [rstt_pkg::STAMP_W-1:0]      req_now_ms,
   input  logic                              rsp_valid,
   input  logic [rstt_pkg::STATUS_W-1:0]     rsp_status,
   input  logic [rstt_pkg::SEQ_W-1:0]        rsp_seq_out,
   input  logic [rstt_pkg::HANDLE_W-1:0]     rsp_handle_out,
   input  logic [rstt_pkg::STAMP_W-1:0]      rsp_oldest_age,
   input  logic [CNT_W-1:0]                  rsp_pending_count,
   input  logic                              rsp_last,
   input  logic                              csr_write_enable,
   input  logic [rstt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rstt_pkg::TMO_W-1:0]        csr_write_data,
   output int                                fail_count,
   output int                                pending_results
);
   import rstt_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SEQ_W-1:0]    seq;
      logic [HANDLE_W-1:0] handle;
      logic [STAMP_W-1:0]  age;
      logic [CNT_W-1:0]    count;
      logic                last;
   } result_type;

   result_type expected_q[$];

   // table kept in insertion order, oldest first
   entry_type    table_q[$];
   logic         reliable;
   logic [TMO_W-1:0] timeout;
   logic [SEQ_W-1:0] seq_counter;

   function automatic result_type make_result(logic [STATUS_W-1:0] st,
                                              logic [SEQ_W-1:0] sq,
                                              logic [HANDLE_W-1:0] h,
                                              logic [STAMP_W-1:0] a,
                                              logic l);
      result_type r;
      r.status = st; r.seq = sq; r.handle = h; r.age = a;
      r.count = CNT_W'(table_q.size()); r.last = l;
      return r;
   endfunction

   task automatic add_expected(result_type r);
      expected_q = {expected_q, r};
   endtask

   task automatic predict_command(logic [CMD_W-1:0] cmd, logic [HANDLE_W-1:0] h,
                                  logic [SEQ_W-1:0] ack, logic [STAMP_W-1:0] now);
      entry_type e;
      int hit;
      int resent;
      logic [STAMP_W-1:0] oldest;
      hit = -1;
      resent = 0;
      oldest = '0;
      case (cmd)
         CMD_SEND, CMD_QUEUE: begin
            if (!reliable)
               add_expected(make_result(ST_SENT_UNRE, '0, h, '0, 1'b1));
            else if (table_q.size() >= DEPTH)
               add_expected(make_result(ST_FULL, '0, h, '0, 1'b1));
            else begin
               seq_counter = seq_counter + SEQ_W'(1);
               e.seq = seq_counter; e.stamp = now; e.first = now; e.handle = h;
               table_q = {table_q, e};
               add_expected(make_result(cmd == CMD_SEND ? ST_SENT_NEW : ST_QUEUED,
                                        seq_counter, h, '0, 1'b1));
            end
         end
         CMD_ACK: begin
            foreach (table_q[i])
               if (hit < 0 && table_q[i].seq == ack) hit = i;
            if (hit < 0)
               add_expected(make_result(ST_ACK_MISS, ack, '0, '0, 1'b1));
            else begin
               e = table_q[hit];
               table_q.delete(hit);
               add_expected(make_result(ST_ACK_HIT, ack, e.handle, '0, 1'b1));
            end
         end
         CMD_TICK: begin
            foreach (table_q[i]) begin
               if (resent < RESENDS && STAMP_W'(now - table_q[i].stamp) > timeout) begin
                  table_q[i].stamp = now;
                  add_expected(make_result(ST_RESEND, table_q[i].seq,
                                           table_q[i].handle, '0, 1'b0));
                  resent++;
               end
               if (STAMP_W'(now - table_q[i].first) > oldest)
                  oldest = now - table_q[i].first;
            end
            add_expected(make_result(ST_TICK_DONE, '0, '0, oldest, 1'b1));
         end
         CMD_CLEAR: begin
            table_q.delete();
            add_expected(make_result(ST_CLEARED, '0, '0, '0, 1'b1));
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("[%0t] mismatch on %s: got %0h expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         reliable    = 1'b1;
         timeout     = 16'd200;
         seq_counter = '0;
         table_q.delete();
         expected_q.delete();
         fail_count  = 0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == REG_RELIABLE_ENABLE) reliable = csr_write_data[0];
            else if (csr_index == REG_RESEND_TIMEOUT) timeout = csr_write_data;
         end
         if (rsp_valid) begin
            if (expected_q.size() == 0)
               report_mismatch("unexpected result", 64'(rsp_status), '0);
            else begin
               want = expected_q.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", 64'(rsp_status), 64'(want.status));
               if (rsp_seq_out !== want.seq)
                  report_mismatch("seq_out", 64'(rsp_seq_out), 64'(want.seq));
               if (rsp_handle_out !== want.handle)
                  report_mismatch("handle_out", 64'(rsp_handle_out), 64'(want.handle));
               if (rsp_oldest_age !== want.age)
                  report_mismatch("oldest_age", 64'(rsp_oldest_age), 64'(want.age));
               if (rsp_pending_count !== want.count)
                  report_mismatch("pending_count", 64'(rsp_pending_count),
                                  64'(want.count));
               if (rsp_last !== want.last)
                  report_mismatch("last", 64'(rsp_last), 64'(want.last));
            end
         end
         if (start && !busy)
            predict_command(req_command, req_payload_handle, req_ack_seq, req_now_ms);
      end
      pending_results = expected_q.size();
   end

endmodule

// ===== test/reliable_send_retransmit_tracker_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reliable_send_retransmit_tracker_tb
// Drives directed and random commands into the retransmission tracker,
// rewrites its registers between phases and reports the checker's verdict.
// ----------------------------------------------------------------------------
module reliable_send_retransmit_tracker_tb;
   import rstt_pkg::*;

   localparam int CNT_W = 5;
   // command codes with no meaning, dropped by the block
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [CMD_W-1:0]     req_command = '0;
   logic [HANDLE_W-1:0]  req_payload_handle = '0;
   logic [SEQ_W-1:0]     req_ack_seq = '0;
   logic [STAMP_W-1:0]   req_now_ms = '0;
   logic                 rsp_valid;
   logic [STATUS_W-1:0]  rsp_status;
   logic [SEQ_W-1:0]     rsp_seq_out;
   logic [HANDLE_W-1:0]  rsp_handle_out;
   logic [STAMP_W-1:0]   rsp_oldest_age;
   logic [CNT_W-1:0]     rsp_pending_count;
   logic                 rsp_last;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [TMO_W-1:0]     csr_write_data = '0;
   int                   fail_count;
   int                   pending_results;

   logic [STAMP_W-1:0]   clock_ms;
   logic [SEQ_W-1:0]     issued_seq;
   bit                   calm;

   always #5 clock = ~clock;

   reliable_send_retransmit_tracker dut (.*);

   reliable_send_retransmit_tracker_checker #(.CNT_W(CNT_W)) checker_i (.*);

   // start stays high after the accepting edge; the next call or drain moves it
   task automatic issue(logic [CMD_W-1:0] cmd, logic [HANDLE_W-1:0] h,
                        logic [SEQ_W-1:0] ack, logic [STAMP_W-1:0] now);
      while (!calm && $urandom_range(0, 99) < 10) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start              <= 1'b1;
      req_command        <= cmd;
      req_payload_handle <= h;
      req_ack_seq        <= ack;
      req_now_ms         <= now;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [TMO_W-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // mostly sends with acks of live sequence numbers, ticks to force resends
   task automatic random_item();
      int pick;
      logic [CMD_W-1:0] cmd;
      logic [SEQ_W-1:0] ack;
      pick = $urandom_range(0, 99);
      clock_ms = clock_ms + $urandom_range(0, 150);
      ack = (issued_seq > 0) ? issued_seq - $urandom_range(0, 17) : 0;
      if (pick < 35) cmd = CMD_SEND;
      else if (pick < 50) cmd = CMD_QUEUE;
      else if (pick < 72) cmd = CMD_ACK;
      else if (pick < 92) cmd = CMD_TICK;
      else if (pick < 96) cmd = CMD_CLEAR;
      else cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      if (cmd == CMD_ACK && $urandom_range(0, 5) == 0) ack = $urandom;
      if (cmd <= CMD_QUEUE) issued_seq = issued_seq + 1;
      issue(cmd, HANDLE_W'($urandom), ack,
            ($urandom_range(0, 30) == 0) ? $urandom : clock_ms);
   endtask

   initial begin
      clock_ms = 0;
      issued_seq = 0;
      calm = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: empty tick, miss, fill to full, resends, wrap of time
      issue(CMD_TICK, 8'h00, '0, 32'h0);
      issue(CMD_ACK, 8'hff, 32'hffff_ffff, 32'h0);
      for (int i = 0; i < 17; i++)
         issue(i[0] ? CMD_QUEUE : CMD_SEND, 8'(i * 15), '0, 32'hffff_fff0 + i);
      issue(CMD_TICK, 8'h00, '0, 32'h0000_1000);
      issue(CMD_ACK, 8'h00, 32'd1, 32'h0);
      issue(CMD_ACK, 8'h00, 32'd9, 32'h0);
      issue(CMD_TICK, 8'hff, 32'hffff_ffff, 32'hffff_ffff);
      issue(CMD_SPARE_LO, 8'h00, '0, '0);
      issue(CMD_CLEAR, 8'h00, '0, '0);
      drain();
      write_reg(REG_RELIABLE_ENABLE, 16'd0);
      write_reg(REG_RESEND_TIMEOUT, 16'hffff);
      issue(CMD_SEND, 8'hff, '0, '0);
      issue(CMD_QUEUE, 8'h00, '0, '0);
      issue(CMD_SPARE_HI, 8'h00, '0, '0);
      drain();
      write_reg(REG_RELIABLE_ENABLE, 16'd1);
      issued_seq = 16;
      for (int phase = 0; phase < 4; phase++) begin
         write_reg(REG_RESEND_TIMEOUT, phase == 0 ? 16'd0 : phase == 1 ? 16'd100 :
                   phase == 2 ? 16'hffff : 16'd200);
         if (phase == 3) write_reg(REG_RELIABLE_ENABLE, 16'd0);
         calm = (phase == 1);
         for (int n = 0; n < 55; n++) begin
            if (phase == 3 && n == 20) begin
               drain();
               write_reg(REG_RELIABLE_ENABLE, 16'd1);
            end
            random_item();
         end
         drain();
      end
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #2ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/rstt_pkg.sv
rtl/core/rstt_cell.sv
rtl/core/reliable_send_retransmit_tracker.sv
test/reliable_send_retransmit_tracker_checker.sv
test/reliable_send_retransmit_tracker_tb.sv
